/* design/rhc_pkg.sv */
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned HUE_W     = 16;
  localparam int unsigned QUO_W     = 14;
  localparam int unsigned REM_W     = 22;
  localparam int unsigned DIV_STEPS = QUO_W;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [QUO_W-1:0]  quo_t;
  typedef logic [REM_W-1:0]  rem_t;

  localparam quo_t  HUE_SIXTH      = 14'd10922;
  localparam hue_t  HUE_ZERO       = 16'd0;
  localparam hue_t  HUE_THIRD      = 16'd21845;
  localparam hue_t  HUE_TWO_THIRDS = 16'd43690;
  localparam hue_t  HUE_FULL       = 16'd65535;
  localparam chan_t CHAN_MAX       = 8'd255;

  typedef enum logic {
    HUE_ADD,
    HUE_SUB
  } hue_op_t;

  typedef struct packed {
    chan_t   num;
    chan_t   den;
    logic    rnd_up;
    hue_op_t op;
    hue_t    base;
    chan_t   value;
    chan_t   span;
  } sector_t;

  typedef struct packed {
    rem_t  rem;
    chan_t den;
    quo_t  quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t hue_lane;
    div_lane_t sat_lane;
    hue_op_t   op;
    hue_t      base;
    chan_t     value;
  } div_item_t;

  // one restoring step: try den << sh against the running remainder
  function automatic div_lane_t div_step(div_lane_t l, int unsigned sh);
    div_lane_t res;
    rem_t      trial;
    res   = l;
    trial = rem_t'(l.den) << sh;
    if (l.rem >= trial) begin
      res.rem = l.rem - trial;
      res.quo = l.quo | (quo_t'(1) << sh);
    end
    return res;
  endfunction

endpackage

/* design/rhc_front.sv */
`timescale 1ns / 1ps

module rhc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_color_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rhc_pkg::div_item_t  out_item
);

  rhc_pkg::chan_t     red, green, blue, mx, mn;
  rhc_pkg::sector_t   sec_nxt, sec_r;
  rhc_pkg::div_item_t item_nxt, item_r;
  logic               va_r, vb_r;
  logic               ready_a, ready_b;

  assign red   = in_color_word[31:24];
  assign green = in_color_word[23:16];
  assign blue  = in_color_word[15:8];

  assign ready_b  = !vb_r || out_ready;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  always_comb begin
    sec_nxt.value = mx;
    sec_nxt.span  = mx - mn;
    sec_nxt.den   = (mx == mn) ? rhc_pkg::chan_t'(1) : mx - mn;
    if (red >= green && green >= blue) begin
      sec_nxt.base   = rhc_pkg::HUE_ZERO;
      sec_nxt.op     = rhc_pkg::HUE_ADD;
      sec_nxt.rnd_up = 1'b0;
      sec_nxt.num    = green - blue;
    end else if (green > red && red >= blue) begin
      sec_nxt.base   = rhc_pkg::HUE_THIRD;
      sec_nxt.op     = rhc_pkg::HUE_SUB;
      sec_nxt.rnd_up = 1'b1;
      sec_nxt.num    = red - blue;
    end else if (green >= blue && blue > red) begin
      sec_nxt.base   = rhc_pkg::HUE_THIRD;
      sec_nxt.op     = rhc_pkg::HUE_ADD;
      sec_nxt.rnd_up = 1'b0;
      sec_nxt.num    = blue - red;
    end else if (blue > green && green > red) begin
      sec_nxt.base   = rhc_pkg::HUE_TWO_THIRDS;
      sec_nxt.op     = rhc_pkg::HUE_SUB;
      sec_nxt.rnd_up = 1'b1;
      sec_nxt.num    = green - red;
    end else if (blue > red && red >= green) begin
      sec_nxt.base   = rhc_pkg::HUE_TWO_THIRDS;
      sec_nxt.op     = rhc_pkg::HUE_ADD;
      sec_nxt.rnd_up = 1'b0;
      sec_nxt.num    = red - green;
    end else begin
      sec_nxt.base   = rhc_pkg::HUE_FULL;
      sec_nxt.op     = rhc_pkg::HUE_SUB;
      sec_nxt.rnd_up = 1'b1;
      sec_nxt.num    = blue - green;
    end
  end

  // dividends: 10922*num (+ den-1 for ceiling) and span*255
  always_comb begin
    item_nxt.op             = sec_r.op;
    item_nxt.base           = sec_r.base;
    item_nxt.value          = sec_r.value;
    item_nxt.hue_lane.den   = sec_r.den;
    item_nxt.hue_lane.quo   = '0;
    item_nxt.hue_lane.rem   = rhc_pkg::rem_t'(sec_r.num) * rhc_pkg::rem_t'(rhc_pkg::HUE_SIXTH)
                            + (sec_r.rnd_up ? rhc_pkg::rem_t'(sec_r.den - 8'd1) : '0);
    item_nxt.sat_lane.den   = (sec_r.value == '0) ? rhc_pkg::chan_t'(1) : sec_r.value;
    item_nxt.sat_lane.quo   = '0;
    item_nxt.sat_lane.rem   = rhc_pkg::rem_t'(sec_r.span) * rhc_pkg::rem_t'(rhc_pkg::CHAN_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready_a) sec_r <= sec_nxt;
    if (va_r && ready_b) item_r <= item_nxt;
  end

  assign out_valid = vb_r;
  assign out_item  = item_r;

  a_dens_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (item_r.hue_lane.den != '0) && (item_r.sat_lane.den != '0))
    else $error("divider lane entered with zero divisor");

endmodule

/* design/rhc_div_step.sv */
`timescale 1ns / 1ps

module rhc_div_step #(
  parameter int unsigned STEP_BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhc_pkg::div_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rhc_pkg::div_item_t  out_item
);

  rhc_pkg::div_item_t item_nxt, item_r;
  logic               valid_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    item_nxt          = in_item;
    item_nxt.hue_lane = rhc_pkg::div_step(in_item.hue_lane, STEP_BIT);
    item_nxt.sat_lane = rhc_pkg::div_step(in_item.sat_lane, STEP_BIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  a_hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> item_r.hue_lane.rem < (rhc_pkg::rem_t'(item_r.hue_lane.den) << STEP_BIT))
    else $error("hue remainder out of range after step");

  a_sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> item_r.sat_lane.rem < (rhc_pkg::rem_t'(item_r.sat_lane.den) << STEP_BIT))
    else $error("saturation remainder out of range after step");

endmodule

/* design/rhc_post.sv */
`timescale 1ns / 1ps

module rhc_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhc_pkg::div_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_hue,
  output logic [7:0]          out_saturation,
  output logic [7:0]          out_brightness
);

  rhc_pkg::hue_t  hue_nxt, hue_r;
  rhc_pkg::chan_t sat_r, bright_r;
  logic           valid_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    case (in_item.op)
      rhc_pkg::HUE_ADD: hue_nxt = in_item.base + rhc_pkg::hue_t'(in_item.hue_lane.quo);
      rhc_pkg::HUE_SUB: hue_nxt = in_item.base - rhc_pkg::hue_t'(in_item.hue_lane.quo);
      default:          hue_nxt = rhc_pkg::HUE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hue_r    <= hue_nxt;
      sat_r    <= in_item.sat_lane.quo[rhc_pkg::CHAN_W-1:0];
      bright_r <= in_item.value;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (bright_r == '0) |-> (sat_r == '0) && (hue_r == '0))
    else $error("black item with nonzero hue or saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (sat_r == '0) |-> (hue_r == '0))
    else $error("grey item with nonzero hue");

endmodule

/* design/rgb_to_hsv_converter.sv */
`timescale 1ns / 1ps
// channel | ports                                      | direction
// --------+--------------------------------------------+----------
// input   | in_valid, in_ready, in_color_word[31:0]    | in
// result  | out_valid, out_ready, out_hue[15:0],       | out
//         | out_saturation[7:0], out_brightness[7:0]   |
//
// Pipeline: 2 front stages (sort/sector, dividend products),
// 14 restoring divide steps (one quotient bit each, hue and saturation lanes
// side by side), 1 output stage. Throughput one item per cycle when not stalled.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// Each stage holds while the next one is full and stalled; bubbles close up.

module rgb_to_hsv_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_color_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_hue,
  output logic [7:0]  out_saturation,
  output logic [7:0]  out_brightness
);

  logic               stage_valid [0:rhc_pkg::DIV_STEPS];
  logic               stage_ready [0:rhc_pkg::DIV_STEPS];
  rhc_pkg::div_item_t stage_item  [0:rhc_pkg::DIV_STEPS];

  rhc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_color_word (in_color_word),
    .out_valid     (stage_valid[0]),
    .out_ready     (stage_ready[0]),
    .out_item      (stage_item[0])
  );

  for (genvar k = 0; k < rhc_pkg::DIV_STEPS; k++) begin : g_div
    rhc_div_step #(
      .STEP_BIT (rhc_pkg::DIV_STEPS - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_item   (stage_item[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_item  (stage_item[k+1])
    );
  end

  rhc_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (stage_valid[rhc_pkg::DIV_STEPS]),
    .in_ready       (stage_ready[rhc_pkg::DIV_STEPS]),
    .in_item        (stage_item[rhc_pkg::DIV_STEPS]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule
